// ----- sv/psvm_pkg.sv -----
//------------------------------------------------------------------------------
// psvm_pkg
// Shared types, constants and the sine table entry function for the voice mixer.
//------------------------------------------------------------------------------
`default_nettype none

package psvm_pkg;

   localparam int AMP_W   = 23;
   localparam int FREQ_W  = 23;
   localparam int TIME_W  = 32;
   localparam int RATE_W  = 18;
   localparam int SMTH_W  = 16;
   localparam int TMO_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      OP_TOUCH   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_TICK    = 2'd2,
      OP_PRUNE   = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE     = 3'd0,
      CSR_FSMOOTH  = 3'd1,
      CSR_ASMOOTH  = 3'd2,
      CSR_TIMEOUT  = 3'd3,
      CSR_PTHRESH  = 3'd4
   } csr_index_type;

   // Sine table entry k of depth entries, Q1.15, by the polynomial recipe.
   function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                     input int unsigned depth);
      logic [63:0] p, t, t2, h, s, v;
      logic [1:0]  quad;
      p = (64'(k) << 32) / 64'(depth);
      quad = p[31:30];
      t = {34'd0, p[29:0]};
      if (quad[0]) t = 64'd1073741824 - t;
      t2 = (t * t) >> 30;
      h = 64'd5026995 - ((t2 * 64'd172272) >> 30);
      h = 64'd85569306 - ((t2 * h) >> 30);
      h = 64'd693598668 - ((t2 * h) >> 30);
      h = 64'd1686629713 - ((t2 * h) >> 30);
      s = (t * h) >> 30;
      v = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      if (quad[1]) return -$signed(v[15:0]);
      return $signed(v[15:0]);
   endfunction

endpackage

`default_nettype wire

// ----- sv/psvm_divider.sv -----
//------------------------------------------------------------------------------
// psvm_divider
// Restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module psvm_divider
   import psvm_pkg::*;
#(
   parameter int NUM_W = 47,
   parameter int DEN_W = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W+1:0] trial;

   // one shift-subtract step
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = '0;
      if (start) begin
         q_in = numer; r_in = '0; d_in = denom;
         cnt_in = CNT_W'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, q_ff[NUM_W-1]} - {2'b00, d_ff};
         if (!trial[DEN_W+1]) begin
            r_in = trial[DEN_W:0];
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

`default_nettype wire

// ----- sv/polyphonic_sine_voice_mixer.sv -----
// Touch/release words pass S_TOUCH; an out-of-range index stays idle. A tick
// runs S_TK_MUL, S_TK_DIV and S_TK_WAIT per active voice (47-step phase-increment
// divider), then S_TK_DONE, which waits for the output register. Prune scans every
// voice twice. One word in work at a time; the output register holds a sample while the next word is taken.
// Reset: synchronous, active high; flags clear at once, registers get defaults.
// Voice state lives in one memory with a registered read; unused until touched.
//------------------------------------------------------------------------------
// polyphonic_sine_voice_mixer
// Event-driven sine voice bank with smoothed frequency and amplitude.
//------------------------------------------------------------------------------
`default_nettype none

module polyphonic_sine_voice_mixer
   import psvm_pkg::*;
#(
   parameter int VOICE_COUNT      = 8,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_WIDTH      = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_opcode,
   input  wire logic [7:0]             req_voice_index,
   input  wire logic [FREQ_W-1:0]      req_frequency,
   input  wire logic [AMP_W-1:0]       req_amplitude,
   input  wire logic [TIME_W-1:0]      req_time_ms,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [15:0]          rsp_sample,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);
   localparam int VI_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int VC_W  = $clog2(VOICE_COUNT + 1);
   localparam int TAB_W = $clog2(SINE_TABLE_DEPTH);
   localparam int TIDX_W = PHASE_WIDTH + TAB_W + 1;
   localparam int NUM_W = FREQ_W + PHASE_WIDTH;
   localparam int DEN_W = RATE_W + 8;
   localparam int SUM_W = 48;

   typedef struct packed {
      logic [PHASE_WIDTH-1:0] phase;
      logic [FREQ_W-1:0]      cfreq;
      logic [FREQ_W-1:0]      tfreq;
      logic [AMP_W-1:0]       camp;
      logic [AMP_W-1:0]       tamp;
      logic [TIME_W-1:0]      ttime;
   } voice_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_TOUCH, S_TK_RD, S_TK_MUL, S_TK_DIV, S_TK_WAIT,
      S_TK_DONE, S_PR1_RD, S_PR1, S_PR2_RD, S_PR2
   } state_type;

   // voice memory
   voice_type mem [VOICE_COUNT];
   voice_type rd_ff;
   logic      we;
   logic [VI_W-1:0] wa, ra;
   voice_type wd;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   // sine table
   logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
      assign sine_rom[k] = sine_entry(k, SINE_TABLE_DEPTH);
   end

   // configuration
   logic [RATE_W-1:0] rate_ff;
   logic [SMTH_W-1:0] fs_ff, as_ff;
   logic [TMO_W-1:0]  tmo_ff;
   logic [AMP_W-1:0]  thr_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_W'(48000); fs_ff <= SMTH_W'(655); as_ff <= SMTH_W'(655);
         tmo_ff <= TMO_W'(500); thr_ff <= AMP_W'(256);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RATE:    rate_ff <= csr_data[RATE_W-1:0];
            CSR_FSMOOTH: fs_ff   <= csr_data[SMTH_W-1:0];
            CSR_ASMOOTH: as_ff   <= csr_data[SMTH_W-1:0];
            CSR_TIMEOUT: tmo_ff  <= csr_data[TMO_W-1:0];
            CSR_PTHRESH: thr_ff  <= csr_data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // divider for phase increment
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_q;
   logic [DEN_W-1:0] den;
   logic [FREQ_W-1:0] cur_f_ff;
   assign den = {((rate_ff == '0) ? RATE_W'(1) : rate_ff), 8'd0};

   psvm_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer({cur_f_ff, {PHASE_WIDTH{1'b0}}}), .denom(den),
      .done(div_done), .quot(div_q)
   );

   // control
   state_type state_ff;
   logic [VOICE_COUNT-1:0] act_ff, rel_ff;
   logic [1:0]  op_ff;
   logic [VI_W-1:0] vi_ff;
   logic [FREQ_W-1:0] f_ff;
   logic [AMP_W-1:0]  a_ff;
   logic [TIME_W-1:0] t_ff;
   logic [VC_W-1:0] cnt_ff;
   logic signed [SUM_W-1:0] sum_ff;
   voice_type cur_ff;
   logic [AMP_W-1:0]  cur_a_ff;
   logic signed [15:0] sin_ff;
   logic signed [AMP_W+16:0] prod_ff;
   logic [TIME_W-1:0] newest_ff;
   logic any_ff;
   logic rsp_valid_ff;
   logic signed [15:0] rsp_ff;
   logic out_load;

   // smoothing step: 23x16 multiply with rounding
   function automatic logic [22:0] smooth(input logic [22:0] c, input logic [22:0] t,
                                          input logic [15:0] f);
      logic [22:0] d;
      logic [39:0] m;
      d = (t >= c) ? t - c : c - t;
      m = {17'd0, d} * {24'd0, f} + 40'd32768;
      return (t >= c) ? c + m[38:16] : c - m[38:16];
   endfunction

   // table index = phase * depth >> phase width
   logic [TIDX_W-1:0] tprod;
   logic [TAB_W-1:0]  tidx;
   assign tprod = TIDX_W'(cur_ff.phase) * TIDX_W'(SINE_TABLE_DEPTH);
   assign tidx = tprod[PHASE_WIDTH +: TAB_W];

   logic signed [SUM_W-1:0] mag_s;
   logic [SUM_W-1:0] mag;
   logic signed [SUM_W-1:0] res;
   always_comb begin
      mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      mag_s = $signed(mag >> 23);
      res = sum_ff[SUM_W-1] ? -mag_s : mag_s;
   end

   logic [VI_W-1:0] cv;
   assign cv = cnt_ff[VI_W-1:0];

   // prune decisions for the voice under scan
   logic pr_force, pr_free;
   assign pr_force = act_ff[cv] && !rel_ff[cv] && any_ff &&
                     ((newest_ff - rd_ff.ttime) > TIME_W'(tmo_ff));
   assign pr_free  = act_ff[cv] && (rel_ff[cv] || pr_force) && (rd_ff.camp < thr_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_ff;
   assign out_load = (state_ff == S_TK_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      we = 1'b0; wa = cv; wd = cur_ff; ra = cv; div_start = 1'b0;
      case (state_ff)
         S_IDLE:  ra = req_voice_index[VI_W-1:0];
         S_TOUCH: begin
            we = 1'b1; wa = vi_ff; wd = rd_ff;
            if (!act_ff[vi_ff]) begin
               wd.phase = '0; wd.cfreq = f_ff; wd.camp = '0;
            end
            wd.tfreq = f_ff; wd.tamp = a_ff; wd.ttime = t_ff;
            if (op_ff == OP_RELEASE) begin
               wd = rd_ff; wd.tamp = '0;
            end
         end
         S_TK_DIV: div_start = 1'b1;
         S_TK_WAIT: if (div_done) begin
            we = 1'b1;
            wd = cur_ff; wd.cfreq = cur_f_ff; wd.camp = cur_a_ff;
            wd.phase = cur_ff.phase + div_q[PHASE_WIDTH-1:0];
         end
         S_PR2: begin
            we = act_ff[cv]; wd = rd_ff;
            if (pr_force || pr_free) wd.tamp = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; act_ff <= '0; rel_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               op_ff <= req_opcode; vi_ff <= req_voice_index[VI_W-1:0];
               f_ff <= req_frequency; a_ff <= req_amplitude; t_ff <= req_time_ms;
               cnt_ff <= '0; sum_ff <= '0; any_ff <= 1'b0; newest_ff <= '0;
               case (opcode_type'(req_opcode))
                  OP_TOUCH, OP_RELEASE:
                     state_ff <= (32'(req_voice_index) < VOICE_COUNT) ? S_TOUCH : S_IDLE;
                  OP_TICK:  state_ff <= S_TK_RD;
                  OP_PRUNE: state_ff <= S_PR1_RD;
                  default:  state_ff <= S_IDLE;
               endcase
            end
            S_TOUCH: begin
               if (op_ff == OP_TOUCH) begin
                  act_ff[vi_ff] <= 1'b1; rel_ff[vi_ff] <= 1'b0;
               end else rel_ff[vi_ff] <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_TK_RD: begin
               if (cnt_ff == VC_W'(VOICE_COUNT)) state_ff <= S_TK_DONE;
               else if (!act_ff[cv]) cnt_ff <= cnt_ff + 1'b1;
               else state_ff <= S_TK_MUL;
            end
            S_TK_MUL: begin
               cur_ff <= rd_ff;
               cur_f_ff <= smooth(rd_ff.cfreq, rd_ff.tfreq, fs_ff);
               cur_a_ff <= smooth(rd_ff.camp, rd_ff.tamp, as_ff);
               state_ff <= S_TK_DIV;
            end
            S_TK_DIV: begin
               sin_ff <= sine_rom[tidx];
               state_ff <= S_TK_WAIT;
            end
            S_TK_WAIT: begin
               prod_ff <= $signed({1'b0, cur_a_ff}) * sin_ff;
               if (div_done) begin
                  sum_ff <= sum_ff + SUM_W'(prod_ff);
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_TK_RD;
               end
            end
            S_TK_DONE: if (out_load) begin
               rsp_ff <= (res > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX :
                         (res < SUM_W'(SAMPLE_MIN)) ? SAMPLE_MIN : res[15:0];
               state_ff <= S_IDLE;
            end
            S_PR1_RD: state_ff <= (cnt_ff == VC_W'(VOICE_COUNT)) ? S_PR2_RD : S_PR1;
            S_PR1: begin
               if (act_ff[cv] && !rel_ff[cv]) begin
                  if (!any_ff || rd_ff.ttime > newest_ff) newest_ff <= rd_ff.ttime;
                  any_ff <= 1'b1;
               end
               if (cnt_ff == VC_W'(VOICE_COUNT - 1)) begin
                  cnt_ff <= '0; state_ff <= S_PR2_RD;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1; state_ff <= S_PR1_RD;
               end
            end
            S_PR2_RD: state_ff <= (cnt_ff == VC_W'(VOICE_COUNT)) ? S_IDLE : S_PR2;
            S_PR2: begin
               if (pr_free) begin
                  act_ff[cv] <= 1'b0; rel_ff[cv] <= 1'b0;
               end else if (pr_force) rel_ff[cv] <= 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
               state_ff <= S_PR2_RD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

`default_nettype wire

// ----- tb/tb_polyphonic_sine_voice_mixer.sv -----
//------------------------------------------------------------------------------
// tb_polyphonic_sine_voice_mixer
// Drives touch, release, tick and prune words into the voice mixer, predicts
// every mixed sample from a local copy of the voice bank and checks each one.
//------------------------------------------------------------------------------
`default_nettype none

module tb_polyphonic_sine_voice_mixer;
   import psvm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV    = 8;
   localparam int DEPTH = 1024;
   localparam int PW    = 24;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_opcode = '0;
   logic [7:0]            req_voice_index = '0;
   logic [FREQ_W-1:0]     req_frequency = '0;
   logic [AMP_W-1:0]      req_amplitude = '0;
   logic [TIME_W-1:0]     req_time_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [15:0]    rsp_sample;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   polyphonic_sine_voice_mixer i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0]  sine_rom [DEPTH];
   logic [RATE_W-1:0]   rate_hz;
   logic [SMTH_W-1:0]   f_smooth, a_smooth;
   logic [TMO_W-1:0]    timeout_ms;
   logic [AMP_W-1:0]    quiet_level;
   bit                  v_on [NV];
   bit                  v_rel [NV];
   logic [PW-1:0]       v_phase [NV];
   logic [FREQ_W-1:0]   f_cur [NV], f_tgt [NV];
   logic [AMP_W-1:0]    a_cur [NV], a_tgt [NV];
   logic [TIME_W-1:0]   t_touch [NV];

   logic signed [15:0]  pending_samples [$];
   int                  errors = 0;
   int                  send_idle = 0;
   int                  recv_idle = 0;

   // sine table built from the polynomial recipe
   function automatic logic signed [15:0] build_sine(int unsigned k);
      logic [63:0] p, t, t2, h, s, v;
      p = (64'(k) << 32) / DEPTH;
      t = {34'd0, p[29:0]};
      if (p[30]) t = 64'd1073741824 - t;
      t2 = (t * t) >> 30;
      h = 64'd5026995 - ((t2 * 64'd172272) >> 30);
      h = 64'd85569306 - ((t2 * h) >> 30);
      h = 64'd693598668 - ((t2 * h) >> 30);
      h = 64'd1686629713 - ((t2 * h) >> 30);
      s = (t * h) >> 30;
      v = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return p[31] ? -$signed(v[15:0]) : $signed(v[15:0]);
   endfunction

   function automatic logic [22:0] glide(logic [22:0] cur, logic [22:0] tgt,
                                         logic [15:0] k);
      logic [63:0] m;
      if (tgt >= cur) begin
         m = (64'(tgt - cur) * k + 64'd32768) >> 16;
         return cur + m[22:0];
      end
      m = (64'(cur - tgt) * k + 64'd32768) >> 16;
      return cur - m[22:0];
   endfunction

   function automatic logic signed [15:0] mix_frame();
      longint      acc;
      logic [63:0] rate, idx, inc, mag;
      longint      res;
      acc = 0;
      rate = (rate_hz == 0) ? 64'd1 : 64'(rate_hz);
      for (int i = 0; i < NV; i++) begin
         if (!v_on[i]) continue;
         f_cur[i] = glide(f_cur[i], f_tgt[i], f_smooth);
         a_cur[i] = glide(a_cur[i], a_tgt[i], a_smooth);
         idx = (64'(v_phase[i]) * DEPTH) >> PW;
         acc += longint'(a_cur[i]) * longint'(sine_rom[idx]);
         inc = (64'(f_cur[i]) << PW) / (rate << 8);
         v_phase[i] = v_phase[i] + inc[PW-1:0];
      end
      if (acc >= 0) begin
         mag = 64'(acc) >> 23;
         res = longint'(mag);
      end else begin
         mag = 64'(-acc) >> 23;
         res = -longint'(mag);
      end
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return 16'(res);
   endfunction

   function automatic void prune_bank();
      logic [31:0] newest;
      bit          any;
      newest = 0;
      any = 0;
      for (int i = 0; i < NV; i++)
         if (v_on[i] && !v_rel[i]) begin
            if (!any || t_touch[i] > newest) newest = t_touch[i];
            any = 1;
         end
      for (int i = 0; i < NV; i++) begin
         if (!v_on[i]) continue;
         if (!v_rel[i] && any && (newest - t_touch[i]) > 32'(timeout_ms)) begin
            a_tgt[i] = 0;
            v_rel[i] = 1;
         end
         if (v_rel[i] && a_cur[i] < quiet_level) begin
            a_tgt[i] = 0;
            v_on[i] = 0;
            v_rel[i] = 0;
         end
      end
   endfunction

   function automatic void apply_word(opcode_type op, logic [7:0] v, logic [22:0] f,
                                      logic [22:0] a, logic [31:0] ms);
      case (op)
         OP_TOUCH: begin
            if (v < NV) begin
               if (!v_on[v]) begin
                  v_on[v] = 1;
                  v_phase[v] = 0;
                  f_cur[v] = f;
                  a_cur[v] = 0;
               end
               v_rel[v] = 0;
               f_tgt[v] = f;
               a_tgt[v] = a;
               t_touch[v] = ms;
            end
         end
         OP_RELEASE: begin
            if (v < NV) begin
               v_rel[v] = 1;
               a_tgt[v] = 0;
            end
         end
         OP_TICK: pending_samples.push_back(mix_frame());
         default: prune_bank();
      endcase
   endfunction

   // send one word, predicting at acceptance; valid drops at the next idle
   task automatic send_word(opcode_type op, logic [7:0] v, logic [22:0] f,
                            logic [22:0] a, logic [31:0] ms);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_voice_index <= v;
      req_frequency <= f;
      req_amplitude <= a;
      req_time_ms <= ms;
      do @(posedge clock); while (!req_ready);
      apply_word(op, v, f, a, ms);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      // a trailing prune may still be scanning
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RATE:    rate_hz = val[RATE_W-1:0];
         CSR_FSMOOTH: f_smooth = val[SMTH_W-1:0];
         CSR_ASMOOTH: a_smooth = val[SMTH_W-1:0];
         CSR_TIMEOUT: timeout_ms = val[TMO_W-1:0];
         default:     quiet_level = val[AMP_W-1:0];
      endcase
      @(negedge clock);
   endtask

   task automatic set_regs(logic [31:0] r, logic [31:0] fs, logic [31:0] as,
                           logic [31:0] to, logic [31:0] pt);
      drain();
      write_reg(CSR_RATE, r);
      write_reg(CSR_FSMOOTH, fs);
      write_reg(CSR_ASMOOTH, as);
      write_reg(CSR_TIMEOUT, to);
      write_reg(CSR_PTHRESH, pt);
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $error("sample: unexpected word %0d", rsp_sample);
            errors++;
         end else begin
            logic signed [15:0] exp_s;
            exp_s = pending_samples.pop_front();
            if (rsp_sample !== exp_s) begin
               $error("sample: expected %0d actual %0d", exp_s, rsp_sample);
               errors++;
            end
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);

   task automatic test_directed();
      send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_RELEASE, 3, 0, 0, 0);
      send_word(OP_TOUCH, 0, 23'h7fffff, 23'h7fffff, 32'hffffffff);
      send_word(OP_TOUCH, 1, 23'd440 << 8, 23'd20000 << 8, 32'd1000);
      send_word(OP_TOUCH, 7, 0, 0, 0);
      send_word(OP_TOUCH, 8, 23'd100 << 8, 23'h7fffff, 5);
      send_word(OP_RELEASE, 255, 0, 0, 0);
      repeat (4) send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_PRUNE, 0, 0, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_RELEASE, 0, 0, 0, 0);
      send_word(OP_RELEASE, 1, 0, 0, 0);
      send_word(OP_RELEASE, 7, 0, 0, 0);
      send_word(OP_PRUNE, 0, 0, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_TOUCH, 3, 23'd1000 << 8, 23'd8000 << 8, 0);
      send_word(OP_TICK, 0, 0, 0, 0);
      // zero rate, instant smoothing, prune with no held voice
      set_regs(0, 65535, 65535, 0, 23'h7fffff);
      send_word(OP_TOUCH, 2, 23'h7fffff, 23'h7fffff, 7);
      repeat (3) send_word(OP_TICK, 0, 0, 0, 0);
      send_word(OP_RELEASE, 2, 0, 0, 0);
      send_word(OP_RELEASE, 3, 0, 0, 0);
      send_word(OP_PRUNE, 0, 0, 0, 0);
      send_word(OP_TICK, 0, 0, 0, 0);
   endtask

   task automatic random_word();
      int unsigned sel;
      logic [7:0]  v;
      sel = $urandom_range(99);
      v = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(NV - 1));
      if (sel < 25)
         send_word(OP_TOUCH, v,
                   $urandom_range(3) == 0 ? 23'($urandom) : 23'($urandom_range(4000 << 8)),
                   23'($urandom), $urandom_range(3) == 0 ? $urandom : $urandom_range(2000));
      else if (sel < 37) send_word(OP_RELEASE, v, 23'($urandom), 23'($urandom), $urandom);
      else if (sel < 87) send_word(OP_TICK, v, 23'($urandom), 23'($urandom), $urandom);
      else send_word(OP_PRUNE, v, 23'($urandom), 23'($urandom), $urandom);
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) random_word();
   endtask

   task automatic test_pause();
      test_random(20);
      drain();
      test_random(20);
   endtask

   initial begin
      for (int k = 0; k < DEPTH; k++) sine_rom[k] = build_sine(k);
      rate_hz = 48000; f_smooth = 655; a_smooth = 655; timeout_ms = 500;
      quiet_level = 256;
      for (int i = 0; i < NV; i++) begin
         v_on[i] = 0; v_rel[i] = 0; v_phase[i] = 0; f_cur[i] = 0; f_tgt[i] = 0;
         a_cur[i] = 0; a_tgt[i] = 0; t_touch[i] = 0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      set_regs(192000, 0, 0, 65535, 0);
      send_idle = 9; recv_idle = 58;
      test_random(600);
      set_regs(8000, 20000, 40000, 300, 4096);
      send_idle = 58; recv_idle = 9;
      test_random(600);
      set_regs(48000, 655, 655, 500, 256);
      send_idle = 0; recv_idle = 0;
      test_pause();
      test_random(580);
      drain();
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule

`default_nettype wire
